// ===== hw/rtl/bf7_pkg.sv =====
package bf7_pkg;

  localparam int unsigned MAX_COLS     = 1024;
  localparam int unsigned RADIUS       = 3;
  localparam int unsigned LINES        = 2 * RADIUS;
  localparam int unsigned WIN          = 2 * RADIUS + 1;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned COL_W        = 10;
  localparam int unsigned ROW_W        = 12;
  localparam int unsigned LANE_W       = 3;
  localparam int unsigned VSUM_W       = 11;
  localparam int unsigned HSUM_W       = 14;
  localparam int unsigned LS_DATA_W    = LINES * PIX_W;

  localparam int unsigned WIDTH_REG_W  = 11;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 13;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_MIN   = 11'd7;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_MAX   = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MIN  = 13'd7;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MAX  = 13'd4096;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST   = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST  = 13'd1024;

  // x / 49 == (x * 21400) >> 20 for every x below 43690
  localparam int unsigned DIV_MUL_W    = 15;
  localparam int unsigned DIV_SHIFT    = 20;
  localparam int unsigned PROD_W       = HSUM_W + DIV_MUL_W;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 15'd21400;
  localparam logic [HSUM_W-1:0] HSUM_MAX = 14'd12495;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              en;
    logic [COL_W-1:0]  addr;
    logic [LANE_W-1:0] lane;
    logic [PIX_W-1:0]  data;
  } ls_wr_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
  } ls_rd_t;

endpackage

// ===== hw/rtl/bf7_line_store.sv =====
module bf7_line_store (
  input  logic                          clk_i,
  input  bf7_pkg::ls_wr_t               wr_i,
  input  bf7_pkg::ls_rd_t               rd_i,
  output logic [bf7_pkg::LS_DATA_W-1:0] rd_data_o
);
  import bf7_pkg::*;

  // one word per column, one byte lane per stored line
  logic [LS_DATA_W-1:0] mem [MAX_COLS];
  logic [LS_DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr][{wr_i.lane, 3'b000} +: PIX_W] <= wr_i.data;
    end
    // read-before-write on the same column
    if (rd_i.en) begin
      rd_data_q <= mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/box_filter_7x7_separable.sv =====
// 7x7 box mean filter over a raster stream of 8-bit pixels. One pixel is
// accepted every clock while the result side keeps up; the line store takes
// one read and one byte write per cycle, which sets that rate. The pixel that
// completes a window goes through the line store read, column sum and window
// shift, window sum and divide by 49 registers on its way out. Pixels within three
// of an image edge give no result. tuser marks the first pixel of a frame and
// restarts the row and column counters; tlast marks the frame's last result.
// Sizes are clamped to 7..1024 columns and 7..4096 rows and must only be
// written while the block is idle. The line store is not cleared after reset.
module box_filter_7x7_separable (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bf7_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bf7_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // [7:0] pixel_value
  input  logic                           s_axis_tuser_i,  // frame_start
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [7:0] smoothed_value, [19:8] center_row, [29:20] center_col, [31:30] zero
  output logic [31:0]                    m_axis_tdata_o,
  output logic                           m_axis_tlast_o   // frame_last
);
  import bf7_pkg::*;

  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [WIDTH_REG_W-1:0]  cfg_w;
  logic [HEIGHT_REG_W-1:0] cfg_h;

  logic [ROW_W-1:0]  row_q, row_d, row_cur;
  logic [COL_W-1:0]  col_q, col_d, col_cur;
  logic [LANE_W-1:0] slot_q, slot_d, slot_cur;
  logic              col_last, row_last, produce;

  logic advance, in_acc;

  ls_wr_t               ls_wr;
  ls_rd_t               ls_rd;
  logic [LS_DATA_W-1:0] ls_rd_data;

  logic              s1_valid_q, s1_prod_q, s1_last_q;
  logic [PIX_W-1:0]  s1_pix_q;
  logic [ROW_W-1:0]  s1_row_q;
  logic [COL_W-1:0]  s1_col_q;

  logic [VSUM_W-1:0] vsum;
  logic [VSUM_W-1:0] win_q [WIN];

  logic              s2_valid_q, s2_last_q;
  logic [ROW_W-1:0]  s2_row_q;
  logic [COL_W-1:0]  s2_col_q;

  logic [HSUM_W-1:0] hsum;
  logic              s3_valid_q, s3_last_q;
  logic [HSUM_W-1:0] s3_hsum_q;
  logic [ROW_W-1:0]  s3_row_q;
  logic [COL_W-1:0]  s3_col_q;

  logic [PROD_W-1:0] prod;
  logic              out_valid_q, out_last_q;
  logic [PIX_W-1:0]  out_mean_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;

  // ---- configuration, clamped on write ----
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_w = cfg_data_i[WIDTH_REG_W-1:0];
    if (cfg_w < WIDTH_MIN) begin
      cfg_w = WIDTH_MIN;
    end else if (cfg_w > WIDTH_MAX) begin
      cfg_w = WIDTH_MAX;
    end
    cfg_h = cfg_data_i[HEIGHT_REG_W-1:0];
    if (cfg_h < HEIGHT_MIN) begin
      cfg_h = HEIGHT_MIN;
    end else if (cfg_h > HEIGHT_MAX) begin
      cfg_h = HEIGHT_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_w;
        CFG_IMAGE_HEIGHT: height_q <= cfg_h;
        default: ;
      endcase
    end
  end

  // ---- whole pipeline moves unless the output register is full and held ----
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = advance;
  assign in_acc          = s_axis_tvalid_i && advance;

  // ---- raster position ----
  always_comb begin
    row_cur  = s_axis_tuser_i ? '0 : row_q;
    col_cur  = s_axis_tuser_i ? '0 : col_q;
    slot_cur = s_axis_tuser_i ? '0 : slot_q;
    col_last = ({1'b0, col_cur} + WIDTH_REG_W'(1)) >= width_q;
    row_last = ({1'b0, row_cur} + HEIGHT_REG_W'(1)) >= height_q;
    produce  = (row_cur >= ROW_W'(LINES)) && (col_cur >= COL_W'(LINES));
    if (col_last) begin
      col_d = '0;
      if (row_last) begin
        row_d  = '0;
        slot_d = '0;
      end else begin
        row_d  = row_cur + ROW_W'(1);
        slot_d = (slot_cur == LANE_W'(LINES - 1)) ? '0 : slot_cur + LANE_W'(1);
      end
    end else begin
      col_d  = col_cur + COL_W'(1);
      row_d  = row_cur;
      slot_d = slot_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else if (in_acc) begin
      row_q  <= row_d;
      col_q  <= col_d;
      slot_q <= slot_d;
    end
  end

  // ---- line store: read all lines of this column, overwrite the oldest ----
  always_comb begin
    ls_wr.en   = in_acc;
    ls_wr.addr = col_cur;
    ls_wr.lane = slot_cur;
    ls_wr.data = s_axis_tdata_i[PIX_W-1:0];
    ls_rd.en   = advance;
    ls_rd.addr = col_cur;
  end

  bf7_line_store u_line_store (
    .clk_i     (clk_i),
    .wr_i      (ls_wr),
    .rd_i      (ls_rd),
    .rd_data_o (ls_rd_data)
  );

  // ---- stage 1: waits for line store data ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_pix_q  <= s_axis_tdata_i[PIX_W-1:0];
      s1_prod_q <= produce;
      s1_last_q <= col_last && row_last;
      s1_row_q  <= row_cur - ROW_W'(RADIUS);
      s1_col_q  <= col_cur - COL_W'(RADIUS);
    end
  end

  // ---- stage 2: column sum, window shift ----
  always_comb begin
    vsum = VSUM_W'(s1_pix_q);
    for (int k = 0; k < LINES; k++) begin
      vsum = vsum + VSUM_W'(ls_rd_data[k*PIX_W +: PIX_W]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      for (int k = 0; k < WIN; k++) begin
        win_q[k] <= '0;
      end
    end else if (advance) begin
      s2_valid_q <= s1_valid_q && s1_prod_q;
      if (s1_valid_q) begin
        win_q[0] <= vsum;
        for (int k = 1; k < WIN; k++) begin
          win_q[k] <= win_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_last_q <= s1_last_q;
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
    end
  end

  // ---- stage 3: window sum ----
  always_comb begin
    hsum = '0;
    for (int k = 0; k < WIN; k++) begin
      hsum = hsum + HSUM_W'(win_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_hsum_q <= hsum;
      s3_last_q <= s2_last_q;
      s3_row_q  <= s2_row_q;
      s3_col_q  <= s2_col_q;
    end
  end

  // ---- output register: divide by 49 via reciprocal ----
  assign prod = PROD_W'(s3_hsum_q) * PROD_W'(DIV_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_mean_q <= prod[DIV_SHIFT +: PIX_W];
      out_last_q <= s3_last_q;
      out_row_q  <= s3_row_q;
      out_col_q  <= s3_col_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_col_q, out_row_q, out_mean_q};
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= LANE_W'(LINES - 1))
    else $error("line slot out of range");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tuser_i |=> row_q == '0 && col_q == COL_W'(1))
    else $error("frame start did not restart the raster position");

  a_hsum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> s3_hsum_q <= HSUM_MAX)
    else $error("window sum exceeds 49 full-scale pixels");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s3_valid_q))
    else $error("result appeared without a window sum behind it");
`endif

endmodule

// ===== dv/box_filter_7x7_separable_tb.sv =====
`timescale 1ns / 1ps

module box_filter_7x7_separable_tb;
  import bf7_pkg::*;

  localparam int unsigned BOX_AREA = WIN * WIN;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             sof;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] mean;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } mean_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [7:0]            s_axis_tdata_i;   // [7:0] pixel_value
  logic                  s_axis_tuser_i;   // frame_start
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  // [7:0] smoothed_value, [19:8] center_row, [29:20] center_col, [31:30] zero
  logic [31:0]           m_axis_tdata_o;
  logic                  m_axis_tlast_o;   // frame_last

  box_filter_7x7_separable dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // filter state mirrored at transfer time
  bit [PIX_W-1:0]        line_mem [LINES][MAX_COLS];
  bit [VSUM_W-1:0]       col_win [WIN];
  int unsigned           row_pos;
  int unsigned           col_pos;
  logic [WIDTH_REG_W-1:0]  cols_setting;
  logic [HEIGHT_REG_W-1:0] rows_setting;

  pixel_t      pixel_stream[$];
  mean_t       pending_means[$];
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned errors;

  function automatic int unsigned fit_size(int unsigned v, int unsigned hi);
    if (v < WIN) return WIN;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] draw_pixel();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return PIX_W'($urandom_range(255));
  endfunction

  task automatic advance_filter(pixel_t px);
    int unsigned w, h, r, c, vsum, hsum;
    mean_t m;
    w = fit_size(32'(cols_setting), 32'(WIDTH_MAX));
    h = fit_size(32'(rows_setting), 32'(HEIGHT_MAX));
    if (px.sof) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    vsum = 32'(px.value);
    for (int k = 0; k < LINES; k++) vsum += 32'(line_mem[k][c]);
    line_mem[r % LINES][c] = px.value;
    for (int k = WIN - 1; k > 0; k--) col_win[k] = col_win[k-1];
    col_win[0] = vsum[VSUM_W-1:0];
    if (r >= LINES && c >= LINES) begin
      hsum = 0;
      for (int k = 0; k < WIN; k++) hsum += 32'(col_win[k]);
      m.mean = PIX_W'(hsum / BOX_AREA);
      m.row  = ROW_W'(r - RADIUS);
      m.col  = COL_W'(c - RADIUS);
      m.last = (r + 1 >= h) && (c + 1 >= w);
      pending_means.push_back(m);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Raster pixels from the current position; sof mostly on frame boundaries,
  // with the odd restart mid-frame. Some frames are flat to reach 0 and 255.
  task automatic queue_pixels(int unsigned n, bit lead_sof, int unsigned noise_pct);
    int unsigned w, h, r, c;
    logic [PIX_W-1:0] level;
    bit flat;
    pixel_t px;
    w = fit_size(32'(cols_setting), 32'(WIDTH_MAX));
    h = fit_size(32'(rows_setting), 32'(HEIGHT_MAX));
    r = lead_sof ? 0 : row_pos;
    c = lead_sof ? 0 : col_pos;
    flat = 1'b0;
    level = '0;
    for (int i = 0; i < n; i++) begin
      if (r == 0 && c == 0) begin
        flat  = ($urandom_range(4) == 0);
        level = draw_pixel();
        px.sof = (i == 0 && lead_sof) || ($urandom_range(3) != 0);
      end else if ($urandom_range(99) < noise_pct) begin
        px.sof = 1'b1;
        r = 0;
        c = 0;
      end else begin
        px.sof = 1'b0;
      end
      px.value = flat ? level : draw_pixel();
      pixel_stream.push_back(px);
      if (c + 1 >= w) begin
        c = 0;
        r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        c++;
      end
    end
  endtask

  task automatic wait_for_drain();
    while (pixel_stream.size() != 0 || s_axis_tvalid_i || pending_means.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) cols_setting = val[WIDTH_REG_W-1:0];
    else rows_setting = val;
    @(posedge clk_i);
  endtask

  // pixel driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) advance_filter(pixel_stream.pop_front());
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pixel_stream.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pixel_stream[0].value;
          s_axis_tuser_i  <= pixel_stream[0].sof;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_check
    mean_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_means.size() == 0) begin
          $error("result with none pending: tdata %h tlast %b", m_axis_tdata_o,
                 m_axis_tlast_o);
          errors++;
        end else begin
          want = pending_means.pop_front();
          if (m_axis_tdata_o[7:0] !== want.mean) begin
            $error("smoothed_value: expected %0d, actual %0d", want.mean,
                   m_axis_tdata_o[7:0]);
            errors++;
          end
          if (m_axis_tdata_o[19:8] !== want.row) begin
            $error("center_row: expected %0d, actual %0d", want.row, m_axis_tdata_o[19:8]);
            errors++;
          end
          if (m_axis_tdata_o[29:20] !== want.col) begin
            $error("center_col: expected %0d, actual %0d", want.col, m_axis_tdata_o[29:20]);
            errors++;
          end
          if (m_axis_tlast_o !== want.last) begin
            $error("frame_last: expected %0d, actual %0d", want.last, m_axis_tlast_o);
            errors++;
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] wd, hd;
    int unsigned n, noise;
    bit lead;
    errors          = 0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    row_pos         = 0;
    col_pos         = 0;
    cols_setting    = WIDTH_RST;
    rows_setting    = HEIGHT_RST;
    foreach (col_win[k]) col_win[k] = '0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_IMAGE_WIDTH;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // smallest frame, sizes below range and width bits above the register
    write_reg(CFG_IMAGE_WIDTH, 13'h1800);
    write_reg(CFG_IMAGE_HEIGHT, 13'd2);
    for (int i = 0; i < BOX_AREA; i++) pixel_stream.push_back('{value: 8'hFF, sof: i == 0});
    wait_for_drain();

    for (int p = 0; p < 14; p++) begin
      wait_for_drain();
      repeat (16) @(posedge clk_i);
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 82; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 82; end
        default: begin src_idle_pct = 24; snk_stall_pct = 24; end
      endcase
      noise = 2;
      n = $urandom_range(50, 140);
      case (p)
        4: begin
          // a stretch of the widest row, flat out
          wd = 13'd2047;
          hd = 13'd7;
          noise = 0;
          src_idle_pct = 0;
          snk_stall_pct = 0;
        end
        7: begin
          wd = CFG_DATA_W'($urandom_range(7, 9));
          hd = 13'h1FFF;
          n = 200;
        end
        9: begin
          wd = 13'h1808;
          hd = 13'd4096;
        end
        default: begin
          wd = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(0, 6))
                                        : CFG_DATA_W'($urandom_range(7, 14));
          hd = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(0, 6))
                                        : CFG_DATA_W'($urandom_range(7, 14));
        end
      endcase
      // carrying on mid-frame is only safe when the row does not grow
      lead = (fit_size(32'(wd[WIDTH_REG_W-1:0]), 32'(WIDTH_MAX))
              > fit_size(32'(cols_setting), 32'(WIDTH_MAX)))
             || (p % 2 == 0) || p == 7;
      write_reg(CFG_IMAGE_WIDTH, wd);
      write_reg(CFG_IMAGE_HEIGHT, hd);
      if (p == 1 || p == 6) begin
        queue_pixels(n / 2, lead, noise);
        wait_for_drain();
        queue_pixels(n - n / 2, 1'b0, noise);
      end else begin
        queue_pixels(n, lead, noise);
      end
    end

    wait_for_drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
